/* rtl/rle_asd_pkg.sv */
// Package: phase codes, result kinds and helpers for the run-length archive decoder.
package rle_asd_pkg;

  localparam int unsigned PhaseW = 3;
  localparam int unsigned CountW = 7;
  localparam int unsigned KindW  = 2;

  typedef logic [PhaseW-1:0] phase_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [KindW-1:0]  kind_t;

  localparam phase_t PH_HEADER   = 3'd0;
  localparam phase_t PH_NAME     = 3'd1;
  localparam phase_t PH_CONTROL  = 3'd2;
  localparam phase_t PH_LITCOUNT = 3'd3;
  localparam phase_t PH_LITERAL  = 3'd4;
  localparam phase_t PH_REPBYTE  = 3'd5;

  localparam logic [7:0] LiteralMark = 8'h80;

  localparam kind_t KIND_NAME      = 2'd0;
  localparam kind_t KIND_NAME_END  = 2'd1;
  localparam kind_t KIND_RUN       = 2'd2;
  localparam kind_t KIND_ENTRY_END = 2'd3;

  // Positive value of a two's complement byte, zero when not positive.
  function automatic count_t positive_count(input logic [7:0] b);
    positive_count = b[7] ? '0 : b[CountW-1:0];
  endfunction

  // One result item as it sits in the output register.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    count_t     run_length;
  } result_t;

endpackage

/* rtl/rle_archive_stream_decoder.sv */
// Top level: run-length archive stream parser, one byte in per item.
//
// The block takes one archive byte per item on the slave stream and emits
// at most one descriptor per byte on the master stream. It sustains one
// item per clock: the byte is decoded by shallow phase logic in the same
// cycle it is accepted and the descriptor lands in a single output
// register, so the result appears in the cycle after the byte and the next
// byte is taken in that same cycle as long as the output register is empty
// or being drained. Only a stalled, full output register holds off input.
// The first byte of an archive is a header and is dropped. Each entry is a
// name (one name-byte item per byte, then a name-end item on the zero
// terminator) followed by coded data: control 0x00 ends the entry
// (entry-end item), control 0x80 is followed by a signed literal count and
// that many literal bytes (each a run of length 1), any other control is a
// signed repeat count for the next byte (one run item, none when the count
// is zero or negative). tlast on an input byte marks the end of the archive:
// the byte is handled as usual, then the parser returns to the header phase.
// Runs are not expanded here; a downstream stage repeats out_byte
// run_length times.
module rle_archive_stream_decoder
  import rle_asd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // archive_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [14:8] run_length, [15] zero
  output logic [1:0]  m_axis_tuser    // [1:0] kind
);

  phase_t  phase_q, phase_d;
  count_t  lit_left_q, lit_left_d;
  count_t  rep_cnt_q, rep_cnt_d;
  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;
  logic    emit;
  logic    in_fire;

  // Take a new byte whenever the output register is free this cycle.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Phase logic: decode one byte against the current phase.
  always_comb begin
    phase_d    = phase_q;
    lit_left_d = lit_left_q;
    rep_cnt_d  = rep_cnt_q;
    emit       = 1'b0;
    res_d      = '{kind: KIND_NAME, out_byte: '0, run_length: '0};

    unique case (phase_q)
      PH_NAME: begin
        emit = 1'b1;
        if (s_axis_tdata == 8'd0) begin
          res_d.kind = KIND_NAME_END;
          phase_d    = PH_CONTROL;
        end else begin
          res_d.kind       = KIND_NAME;
          res_d.out_byte   = s_axis_tdata;
          res_d.run_length = count_t'(1);
        end
      end
      PH_CONTROL: begin
        if (s_axis_tdata == 8'd0) begin
          emit       = 1'b1;
          res_d.kind = KIND_ENTRY_END;
          phase_d    = PH_NAME;
        end else if (s_axis_tdata == LiteralMark) begin
          phase_d = PH_LITCOUNT;
        end else begin
          // Keep only the positive part; a non-positive count emits nothing.
          rep_cnt_d = positive_count(s_axis_tdata);
          phase_d   = PH_REPBYTE;
        end
      end
      PH_LITCOUNT: begin
        lit_left_d = positive_count(s_axis_tdata);
        phase_d    = (positive_count(s_axis_tdata) != '0) ? PH_LITERAL : PH_CONTROL;
      end
      PH_LITERAL: begin
        emit             = 1'b1;
        res_d.kind       = KIND_RUN;
        res_d.out_byte   = s_axis_tdata;
        res_d.run_length = count_t'(1);
        lit_left_d       = lit_left_q - count_t'(1);
        if (lit_left_d == '0) begin
          phase_d = PH_CONTROL;
        end
      end
      PH_REPBYTE: begin
        emit             = (rep_cnt_q != '0);
        res_d.kind       = KIND_RUN;
        res_d.out_byte   = s_axis_tdata;
        res_d.run_length = rep_cnt_q;
        rep_cnt_d        = '0;
        phase_d          = PH_CONTROL;
      end
      default: begin
        // Header byte (and unused codes): drop it.
        phase_d = PH_NAME;
      end
    endcase

    // Archive end: back to header, clear the counters.
    if (s_axis_tlast) begin
      phase_d    = PH_HEADER;
      lit_left_d = '0;
      rep_cnt_d  = '0;
    end
  end

  // Output register: load on an emitting byte, drop when taken downstream.
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (in_fire && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      lit_left_q  <= '0;
      rep_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        phase_q    <= phase_d;
        lit_left_q <= lit_left_d;
        rep_cnt_q  <= rep_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.run_length, res_q.out_byte};
  assign m_axis_tuser  = res_q.kind;

  // The phase register never holds an unused code.
  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_REPBYTE)
    else $error("phase register holds an unused code");

  // Inside a literal run at least one literal is still owed.
  a_lit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LITERAL) |-> (lit_left_q != '0))
    else $error("literal phase with no literals left");

  // An accepted end-of-archive byte returns the parser to the header phase with the repeat count cleared.
  a_end_to_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tlast) |=> (phase_q == PH_HEADER && rep_cnt_q == '0))
    else $error("archive end did not return to header");

  // Marker items carry no byte and no length; name-byte and run items carry a nonzero length.
  a_result_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (((m_axis_tuser == KIND_NAME_END || m_axis_tuser == KIND_ENTRY_END) &&
        m_axis_tdata == 16'd0) ||
       ((m_axis_tuser == KIND_NAME || m_axis_tuser == KIND_RUN) &&
        m_axis_tdata[14:8] != 7'd0)))
    else $error("malformed result item");

  // A stalled result is not overwritten by a newly accepted byte.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !in_fire)
    else $error("input accepted while output is stalled");

endmodule
